[rtl/hkvt_pkg.sv]
// Package for the hashed key/value table: request and response payload types,
// opcode and status codes. No dependencies.
package hkvt_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0]        new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_t;

endpackage

[rtl/hkvt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module hkvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hashed_key_value_table_top.sv]
// Hashed key/value table: one bucket row per RAM entry (valid bits, keys, values).
// A transfer registers the request and partial hash sums; S_HASH forms the bucket
// index and reads the row; S_LOOK compares, registers the response, writes the row
// back; a new request is taken only in S_IDLE or in S_LOOK. Reset: a clearing pass
// empties every row, taking no request. Depends on hkvt_pkg and hkvt_ram.
module hashed_key_value_table_top
    import hkvt_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int     BW     = $clog2(BUCKETS);
    localparam int     SLOT_W = KEY_W + VAL_W;
    localparam int     ROW_W  = WAYS * (SLOT_W + 1);
    localparam longint NB     = longint'(BUCKETS);
    localparam logic [BW:0]   BMOD = (BW+1)'(BUCKETS);
    localparam logic [BW-1:0] LAST = BW'(BUCKETS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HASH, S_LOOK} state_t;

    state_t          state_reg;
    logic [BW-1:0]   clr_reg;
    logic            rsp_valid_reg;
    rsp_t            rsp_reg;

    req_t            req_reg;
    logic [BW-1:0]   s01_reg, s23_reg, bucket_reg;
    logic [BW-1:0]   s01_next, s23_next, bucket_next;

    logic            out_free, accept;
    logic            ram_we, ram_re;
    logic [BW-1:0]   ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, wr_row;

    logic [BW-1:0]   tab_b0 [256];
    logic [BW-1:0]   tab_b1 [256];
    logic [BW-1:0]   tab_b2 [256];
    logic [BW-1:0]   tab_b3 [256];

    logic [WAYS-1:0]  rd_valid, wr_valid, hit_oh, free_oh;
    logic [KEY_W-1:0] rd_key [WAYS];
    logic [KEY_W-1:0] wr_key [WAYS];
    logic [VAL_W-1:0] rd_val [WAYS];
    logic [VAL_W-1:0] wr_val [WAYS];
    logic             row_upd;
    rsp_t             rsp_next;

    // Residue of each key byte times its weight; the top byte carries the sign.
    for (genvar gd = 0; gd < 256; gd++)
    begin : g_tab
        localparam longint D  = longint'(gd);
        localparam longint SD = (gd >= 128) ? D - 256 : D;
        localparam longint R0 = D % NB;
        localparam longint R1 = (D * 256) % NB;
        localparam longint R2 = (D * 65536) % NB;
        localparam longint R3 = ((SD * 16777216) % NB + NB) % NB;
        assign tab_b0[gd] = BW'(R0);
        assign tab_b1[gd] = BW'(R1);
        assign tab_b2[gd] = BW'(R2);
        assign tab_b3[gd] = BW'(R3);
    end

    function automatic logic [BW-1:0] add_mod(input logic [BW-1:0] a, input logic [BW-1:0] b);
        logic [BW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= BMOD)
        begin
            s = s - BMOD;
        end
        return s[BW-1:0];
    endfunction

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) || (state_reg == S_LOOK && out_free);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [KEY_W-1:0] kb;
        kb          = $unsigned(req.lookup_key);
        s01_next    = add_mod(tab_b0[kb[7:0]], tab_b1[kb[15:8]]);
        s23_next    = add_mod(tab_b2[kb[23:16]], tab_b3[kb[31:24]]);
        bucket_next = add_mod(s01_reg, s23_reg);
    end

    // Unpack the bucket row: valid bits on top, then one key/value slot per way.
    always_comb
    begin
        rd_valid = ram_rdata[ROW_W-1 -: WAYS];
        for (int w = 0; w < WAYS; w++)
        begin
            rd_key[w] = ram_rdata[w*SLOT_W + VAL_W +: KEY_W];
            rd_val[w] = ram_rdata[w*SLOT_W +: VAL_W];
        end
    end

    // Compare all ways; pick the first match and the first free slot.
    always_comb
    begin
        logic found_hit, found_free;
        logic [KEY_W-1:0] kb;
        found_hit  = 1'b0;
        found_free = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        kb         = $unsigned(req_reg.lookup_key);
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_valid[w] && rd_key[w] == kb && !found_hit)
            begin
                hit_oh[w] = 1'b1;
                found_hit = 1'b1;
            end
            if (!rd_valid[w] && !found_free)
            begin
                free_oh[w] = 1'b1;
                found_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_valid = rd_valid;
        row_upd  = 1'b0;
        rsp_next = '{status: STAT_DONE, hit: 1'b0, read_value: '0};
        for (int w = 0; w < WAYS; w++)
        begin
            wr_key[w] = rd_key[w];
            wr_val[w] = rd_val[w];
        end
        unique case (req_reg.opcode)
            OP_PUT:
            begin
                row_upd = (hit_oh != '0) || (free_oh != '0);
                rsp_next.hit = (hit_oh != '0);
                if (!row_upd)
                begin
                    rsp_next.status = STAT_FULL;
                end
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_oh[w])
                    begin
                        wr_val[w] = req_reg.new_value;
                    end
                    else if (hit_oh == '0 && free_oh[w])
                    begin
                        wr_key[w]   = $unsigned(req_reg.lookup_key);
                        wr_val[w]   = req_reg.new_value;
                        wr_valid[w] = 1'b1;
                    end
                end
            end
            OP_GET:
            begin
                rsp_next.hit = (hit_oh != '0);
                if (hit_oh == '0)
                begin
                    rsp_next.status = STAT_MISS;
                end
                for (int w = 0; w < WAYS; w++)
                begin
                    if (hit_oh[w])
                    begin
                        rsp_next.read_value = rd_val[w];
                    end
                end
            end
            OP_REMOVE:
            begin
                row_upd      = (hit_oh != '0);
                rsp_next.hit = (hit_oh != '0);
                if (hit_oh == '0)
                begin
                    rsp_next.status = STAT_MISS;
                end
                wr_valid = rd_valid & ~hit_oh;
            end
            default:
            begin
                row_upd = 1'b0;
            end
        endcase
        wr_row = '0;
        wr_row[ROW_W-1 -: WAYS] = wr_valid;
        for (int w = 0; w < WAYS; w++)
        begin
            wr_row[w*SLOT_W + VAL_W +: KEY_W] = wr_key[w];
            wr_row[w*SLOT_W +: VAL_W]         = wr_val[w];
        end
    end

    always_comb
    begin
        ram_re    = (state_reg == S_HASH);
        ram_we    = 1'b0;
        ram_waddr = bucket_reg;
        ram_wdata = wr_row;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_LOOK && out_free && row_upd)
        begin
            ram_we = 1'b1;
        end
    end

    hkvt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (bucket_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    // Hold the row read data until the response register frees up.
                    if (out_free)
                    begin
                        state_reg <= accept ? S_HASH : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (state_reg == S_LOOK && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            s01_reg <= s01_next;
            s23_reg <= s23_next;
        end
        if (state_reg == S_HASH)
        begin
            bucket_reg <= bucket_next;
        end
    end

    a_rsp_from_look: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_LOOK))
        else $error("response raised outside the lookup state");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("row read and write in the same cycle");

    a_one_slot_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && ram_we) |-> $countones(wr_valid ^ rd_valid) <= 1)
        else $error("more than one slot changed occupancy");

    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_HASH)
        else $error("transfer not followed by the bucket read");

endmodule
